/* src/bsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, constants and shift helpers for the barometric compensation.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int unsigned DIV_STEPS  = 64;
   localparam int unsigned DEN_WIDTH  = 31;
   localparam int unsigned COEF_WIDTH = 48;

   localparam logic [32:0] T_FINE_OFFSET = 33'd128000;
   localparam logic [20:0] P_FULL_SCALE  = 21'd1048576;
   localparam logic [63:0] P_SCALE       = 64'd3125;
   localparam logic [63:0] W1_BIAS       = 64'h0000_8000_0000_0000;

   typedef enum logic [1:0] {
      CSR_TEMP    = 2'd0,
      CSR_PRESS_A = 2'd1,
      CSR_PRESS_B = 2'd2,
      CSR_PRESS_C = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] temp;
      logic        neg;
      logic        bad;
   } div_side_type;

   function automatic logic [31:0] asr32(logic [31:0] x, int unsigned s);
      logic signed [31:0] xs;
      xs = x;
      return xs >>> s;
   endfunction

   function automatic logic [63:0] asr64(logic [63:0] x, int unsigned s);
      logic signed [63:0] xs;
      xs = x;
      return xs >>> s;
   endfunction

endpackage

/* src/bsc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// ----------------------------------------------------------------------------
module bsc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [63:0]              in_num,
   input  logic [30:0]              in_den,
   input  bsc_pkg::div_side_type    in_side,
   output logic                     out_valid,
   output logic [63:0]              out_quot,
   output bsc_pkg::div_side_type    out_side
);
   import bsc_pkg::*;

   logic [DIV_STEPS-1:0] vld_ff;
   logic [DEN_WIDTH-1:0] rem_ff  [DIV_STEPS];
   logic [DEN_WIDTH-1:0] den_ff  [DIV_STEPS];
   logic [63:0]          nq_ff   [DIV_STEPS];
   div_side_type         side_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DEN_WIDTH-1:0] rem_prev;
      logic [DEN_WIDTH-1:0] den_prev;
      logic [63:0]          nq_prev;
      div_side_type         side_prev;
      logic [DEN_WIDTH:0]   trial;
      logic [DEN_WIDTH:0]   diff;
      logic                 ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign den_prev  = in_den;
         assign nq_prev   = in_num;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign nq_prev   = nq_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial = {rem_prev, nq_prev[63]};
      assign diff  = trial - {1'b0, den_prev};
      assign ge    = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
            nq_ff[k]   <= {nq_prev[62:0], ge};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_quot  = nq_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

/* src/barometric_sensor_compensation_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_top
// Path: an accepted item runs through S1..S11, the divider, P1..P5 and the output register to rsp_.
// Throughput: one item per cycle while rsp_ is not stalled; the 64-stage divider pipeline sets depth.
// A stalled rsp_ side holds every stage; req_tready follows the output slot.
// Reset clears all calibration registers and every pipeline valid bit.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // temperature_centi[31:0], pressure_q24_8[63:32]
   output logic        rsp_tuser,   // pressure_invalid
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [47:0] csr_wdata
);
   import bsc_pkg::*;

   logic [COEF_WIDTH-1:0] temp_coeffs_ff, press_a_ff, press_b_ff, press_c_ff;
   logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic        adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_c_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_TEMP:    temp_coeffs_ff <= csr_wdata;
            CSR_PRESS_A: press_a_ff     <= csr_wdata;
            CSR_PRESS_B: press_b_ff     <= csr_wdata;
            CSR_PRESS_C: press_c_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign t1 = temp_coeffs_ff[15:0];
   assign t2 = temp_coeffs_ff[31:16];
   assign t3 = temp_coeffs_ff[47:32];
   assign p1 = press_a_ff[15:0];
   assign p2 = press_a_ff[31:16];
   assign p3 = press_a_ff[47:32];
   assign p4 = press_b_ff[15:0];
   assign p5 = press_b_ff[31:16];
   assign p6 = press_b_ff[47:32];
   assign p7 = press_c_ff[15:0];
   assign p8 = press_c_ff[31:16];
   assign p9 = press_c_ff[47:32];

   logic        rsp_tvalid_ff;
   logic [31:0] rsp_temp_ff, rsp_pres_ff;
   logic        rsp_bad_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // front stages
   logic [10:0] fv_ff;
   logic [19:0] adcp_ff [8];
   logic [31:0] temp_ff [6];
   logic [31:0] diff_ff, d_ff, pa_ff, dd_ff, v1_ff, ddt_ff, fine_ff;
   logic [32:0] w1_ff;
   logic [63:0] sq_ff, m5_ff, m2_ff, m5b_ff, m2b_ff, w2a_ff, w1a_ff;
   logic [63:0] w2_ff, w1b_ff, prodm_ff, numa_ff, num_ff, an_ff;
   logic [30:0] den_ff, ad_ff;
   logic        bad10_ff;
   div_side_type side_ff;
   logic [20:0] pdiff;

   assign pdiff = P_FULL_SCALE - {1'b0, adcp_ff[7]};

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (adv) begin
         fv_ff <= {fv_ff[9:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // S1
         adcp_ff[0] <= req_tdata[39:20];
         diff_ff    <= {15'd0, req_tdata[19:3]} - {15'd0, t1, 1'b0};
         d_ff       <= {16'd0, req_tdata[19:4]} - {16'd0, t1};
         for (int i = 1; i < 8; i++) begin
            adcp_ff[i] <= adcp_ff[i-1];
         end
         // S2
         pa_ff  <= $signed(diff_ff) * $signed(t2);
         dd_ff  <= d_ff * d_ff;
         // S3
         v1_ff  <= asr32(pa_ff, 11);
         ddt_ff <= $signed(asr32(dd_ff, 12)) * $signed(t3);
         // S4
         fine_ff <= v1_ff + asr32(ddt_ff, 14);
         // S5
         temp_ff[0] <= asr32(fine_ff * 32'd5 + 32'd128, 8);
         w1_ff      <= {fine_ff[31], fine_ff} - T_FINE_OFFSET;
         for (int i = 1; i < 6; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
         // S6
         sq_ff <= $signed(w1_ff) * $signed(w1_ff);
         m5_ff <= $signed(w1_ff) * $signed(p5);
         m2_ff <= $signed(w1_ff) * $signed(p2);
         // S7
         w2a_ff <= $signed(sq_ff) * $signed(p6);
         w1a_ff <= $signed(sq_ff) * $signed(p3);
         m5b_ff <= m5_ff;
         m2b_ff <= m2_ff;
         // S8
         w2_ff  <= w2a_ff + (m5b_ff << 17) + ({{48{p4[15]}}, p4} << 35);
         w1b_ff <= asr64(w1a_ff, 8) + (m2b_ff << 12);
         // S9
         prodm_ff <= $signed(w1b_ff + W1_BIAS) * $signed({1'b0, p1});
         numa_ff  <= ({43'd0, pdiff} << 31) - w2_ff;
         // S10
         den_ff   <= prodm_ff[63:33];
         bad10_ff <= prodm_ff[63:33] == '0;
         num_ff   <= numa_ff * P_SCALE;
         // S11
         an_ff         <= num_ff[63] ? 64'd0 - num_ff : num_ff;
         ad_ff         <= den_ff[30] ? 31'd0 - den_ff : den_ff;
         side_ff.temp  <= temp_ff[5];
         side_ff.neg   <= num_ff[63] ^ den_ff[30];
         side_ff.bad   <= bad10_ff;
      end
   end

   logic         dv;
   logic [63:0]  dq;
   div_side_type dside;

   bsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fv_ff[10]),
      .in_num    (an_ff),
      .in_den    (ad_ff),
      .in_side   (side_ff),
      .out_valid (dv),
      .out_quot  (dq),
      .out_side  (dside)
   );

   // back stages
   logic [4:0]   bv_ff;
   div_side_type bs_ff [5];
   logic [63:0]  q1_ff, q2_ff, q3_ff, q4_ff, ps_ff, t_ff, c2_ff, c2b_ff, c2c_ff;
   logic [63:0]  pp0_ff, c1f_ff, sum_ff;
   logic [31:0]  pp1_ff, pp2_ff;
   logic [63:0]  ps_now;

   assign ps_now = asr64(q1_ff, 13);

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         bv_ff         <= {bv_ff[3:0], dv};
         rsp_tvalid_ff <= bv_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bs_ff[0] <= dside;
         for (int i = 1; i < 5; i++) begin
            bs_ff[i] <= bs_ff[i-1];
         end
         // P1
         q1_ff <= dside.neg ? 64'd0 - dq : dq;
         // P2
         q2_ff <= q1_ff;
         ps_ff <= ps_now;
         t_ff  <= $signed(p9) * $signed(ps_now);
         c2_ff <= $signed(p8) * $signed(q1_ff);
         // P3
         q3_ff  <= q2_ff;
         c2b_ff <= c2_ff;
         pp0_ff <= t_ff[31:0] * ps_ff[31:0];
         pp1_ff <= t_ff[31:0] * ps_ff[63:32];
         pp2_ff <= t_ff[63:32] * ps_ff[31:0];
         // P4
         q4_ff  <= q3_ff;
         c2c_ff <= c2b_ff;
         c1f_ff <= pp0_ff + {pp1_ff + pp2_ff, 32'd0};
         // P5
         sum_ff <= q4_ff + asr64(c1f_ff, 25) + asr64(c2c_ff, 19);
         // output
         rsp_temp_ff <= bs_ff[4].temp;
         rsp_bad_ff  <= bs_ff[4].bad;
         rsp_pres_ff <= bs_ff[4].bad ? 32'd0
                      : 32'(asr64(sum_ff, 8) + ({{48{p7[15]}}, p7} << 4));
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_pres_ff, rsp_temp_ff};
   assign rsp_tuser  = rsp_bad_ff;

endmodule

/* tb/barometric_sensor_compensation_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_top_tb
// Self-checking bench for the barometric compensation pipeline. Raw reading
// pairs are streamed under random bursts and output stalls; a local model
// computes compensated temperature and pressure and checks every result.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top_tb;
   import bsc_pkg::*;

   typedef struct packed {
      logic [31:0] temp_centi;
      logic [31:0] press_q;
      logic        invalid;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [47:0] csr_wdata = '0;

   logic [47:0] coef_t, coef_pa, coef_pb, coef_pc;
   reading_type pending_readings[$];
   int          error_count = 0;
   int          checked_count = 0;
   int          invalid_count = 0;
   int          sent_count = 0;
   int          hold_off_cycles = 0;
   int          burst_left = 0;
   int          rx_mode = 0;

   barometric_sensor_compensation_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[barometric_sensor_compensation_top] ERROR");
      $finish;
   end

   function automatic logic [63:0] sext16(logic [47:0] r, int pos);
      logic signed [15:0] f;
      f = r[pos +: 16];
      return 64'(signed'(f));
   endfunction

   function automatic logic [63:0] divide_trunc(logic [63:0] n, logic [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q = an / ad;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   function automatic reading_type compensate(logic [19:0] adc_t, logic [19:0] adc_p);
      reading_type r;
      logic [31:0] t1, t2, t3, a, v1, dd, v2, fine;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, fine64, w1, w2, p, ps, c1, c2;
      t1 = {16'd0, coef_t[15:0]};
      t2 = 32'(sext16(coef_t, 16));
      t3 = 32'(sext16(coef_t, 32));
      a = ((32'(adc_t) >> 3) - (t1 << 1)) * t2;
      v1 = $signed(a) >>> 11;
      dd = (32'(adc_t) >> 4) - t1;
      v2 = asr32(asr32(dd * dd, 12) * t3, 14);
      fine = v1 + v2;
      r.temp_centi = $signed(32'(fine * 32'd5 + 32'd128)) >>> 8;
      p1 = {48'd0, coef_pa[15:0]};
      p2 = sext16(coef_pa, 16); p3 = sext16(coef_pa, 32);
      p4 = sext16(coef_pb, 0);  p5 = sext16(coef_pb, 16); p6 = sext16(coef_pb, 32);
      p7 = sext16(coef_pc, 0);  p8 = sext16(coef_pc, 16); p9 = sext16(coef_pc, 32);
      fine64 = 64'(signed'(fine));
      w1 = fine64 - 64'd128000;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) << 17);
      w2 = w2 + (p4 << 35);
      w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
      w1 = $signed(64'(((64'd1 << 47) + w1) * p1)) >>> 33;
      r.press_q = '0;
      r.invalid = 1'b1;
      if (w1 != 0) begin
         p = 64'd1048576 - 64'(adc_p);
         p = divide_trunc(((p << 31) - w2) * 64'd3125, w1);
         ps = $signed(p) >>> 13;
         c1 = $signed(64'(p9 * ps * ps)) >>> 25;
         c2 = $signed(64'(p8 * p)) >>> 19;
         p = asr64(p + c1 + c2, 8) + (p7 << 4);
         r.press_q = p[31:0];
         r.invalid = 1'b0;
      end
      return r;
   endfunction

   // receiver stall pattern: mode 0 free, 1 random, 2 mostly stalled
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (rx_mode == 0)
         rsp_tready <= 1'b1;
      else if (rx_mode == 1)
         rsp_tready <= ($urandom_range(0, 3) != 0);
      else
         rsp_tready <= ($urandom_range(0, 7) == 0);
   end

   always @(posedge clock) begin
      reading_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser};
         if (pending_readings.size() == 0) begin
            $display("%0t unexpected result %h", $realtime, got);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            checked_count++;
            if (want.invalid) invalid_count++;
            if (got.temp_centi !== want.temp_centi) begin
               $display("%0t temperature_centi expected %h actual %h",
                        $realtime, want.temp_centi, got.temp_centi);
               error_count++;
            end
            if (got.press_q !== want.press_q) begin
               $display("%0t pressure_q24_8 expected %h actual %h",
                        $realtime, want.press_q, got.press_q);
               error_count++;
            end
            if (got.invalid !== want.invalid) begin
               $display("%0t pressure_invalid expected %b actual %b",
                        $realtime, want.invalid, got.invalid);
               error_count++;
            end
         end
      end
   end

   task automatic send_reading(logic [19:0] adc_t, logic [19:0] adc_p, bit gappy);
      if (gappy) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata <= {adc_p, adc_t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_readings.push_back(compensate(adc_t, adc_p));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (90) @(negedge clock);
   endtask

   task automatic write_coeffs(csr_index_type idx, logic [47:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TEMP:    coef_t = value;
         CSR_PRESS_A: coef_pa = value;
         CSR_PRESS_B: coef_pb = value;
         default:     coef_pc = value;
      endcase
   endtask

   task automatic load_typical();
      write_coeffs(CSR_TEMP,    {16'd50, 16'd26435, 16'd27504});
      write_coeffs(CSR_PRESS_A, {16'hD0D0, 16'hD5C8, 16'd36477});
      write_coeffs(CSR_PRESS_B, {16'hFFF9, 16'd140, 16'd2855});
      write_coeffs(CSR_PRESS_C, {16'd6000, 16'hC050, 16'd15500});
   endtask

   task automatic load_random();
      write_coeffs(CSR_TEMP,    48'({$urandom, $urandom}));
      write_coeffs(CSR_PRESS_A, 48'({$urandom, $urandom}));
      write_coeffs(CSR_PRESS_B, 48'({$urandom, $urandom}));
      write_coeffs(CSR_PRESS_C, 48'({$urandom, $urandom}));
   endtask

   task automatic test_reset_coeffs();
      send_reading(20'h80000, 20'h60000, 1'b0);
      send_reading(20'hFFFFF, 20'h00000, 1'b0);
      wait_drained();
   endtask

   task automatic test_directed();
      load_typical();
      send_reading(20'd519888, 20'd415148, 1'b0);
      send_reading(20'd0, 20'd0, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
      send_reading(20'd0, 20'hFFFFF, 1'b0);
      send_reading(20'hFFFFF, 20'd0, 1'b0);
      send_reading(20'h55555, 20'hAAAAA, 1'b0);
      send_reading(20'hAAAAA, 20'h55555, 1'b0);
      wait_drained();
      // extremes of the pressure coefficients, all ones for the temperature set
      write_coeffs(CSR_TEMP,    48'hFFFF_FFFF_FFFF);
      write_coeffs(CSR_PRESS_A, 48'h7FFF_7FFF_FFFF);
      write_coeffs(CSR_PRESS_B, 48'h8000_8000_8000);
      write_coeffs(CSR_PRESS_C, 48'h7FFF_8000_7FFF);
      send_reading(20'd0, 20'd0, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
      send_reading(20'h12345, 20'h6789A, 1'b0);
      wait_drained();
      // P1 zero forces a zero divisor
      write_coeffs(CSR_PRESS_A, 48'h1234_5678_0000);
      send_reading(20'd519888, 20'd415148, 1'b0);
      send_reading(20'hFFFFF, 20'hFFFFF, 1'b0);
      wait_drained();
      write_coeffs(CSR_TEMP,    48'h8000_8000_0000);
      write_coeffs(CSR_PRESS_A, 48'h8000_8000_0001);
      write_coeffs(CSR_PRESS_B, 48'h0);
      write_coeffs(CSR_PRESS_C, 48'h8000_7FFF_8000);
      send_reading(20'hFFFFF, 20'd1, 1'b0);
      send_reading(20'd1, 20'hFFFFE, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_typical(int n);
      load_typical();
      rx_mode = 1;
      for (int i = 0; i < n; i++)
         send_reading(20'($urandom_range(300000, 700000)), 20'($urandom), 1'b1);
      wait_drained();
   endtask

   task automatic test_random_coeffs(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) begin
            wait_drained();
            load_random();
            rx_mode = $urandom_range(0, 2);
         end
         send_reading(20'($urandom), 20'($urandom), 1'b1);
      end
      wait_drained();
   endtask

   task automatic test_back_pressure();
      load_typical();
      rx_mode = 0;
      @(negedge clock);
      hold_off_cycles = 300;
      for (int i = 0; i < 200; i++)
         send_reading(20'($urandom), 20'($urandom), 1'b0);
      wait_drained();
   endtask

   initial begin
      coef_t = '0; coef_pa = '0; coef_pb = '0; coef_pc = '0;
      rx_mode = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_coeffs();
      test_directed();
      test_back_pressure();
      test_random_typical(600);
      test_random_coeffs(700);
      $display("Checked %0d results from %0d items, %0d with a zero divisor,",
               checked_count, sent_count, invalid_count);
      $display("over typical, extreme and random calibrations with stalls.");
      if (error_count == 0 && pending_readings.size() == 0)
         $display("[barometric_sensor_compensation_top] OK");
      else
         $display("[barometric_sensor_compensation_top] ERROR");
      $finish;
   end

endmodule
